// ===== sv/ats_pkg.sv =====
// Shared types, constants and codes for the angle to scroll accumulator.
package ats_pkg;

  localparam int ANGLE_BITS_DEF = 12;
  localparam int ANGLE_IN_W     = 12;
  localparam int LEVEL_W        = 8;
  localparam int AMOUNT_W       = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = LEVEL_W;

  localparam logic [LEVEL_W-1:0] LEVEL_FIRST_RST  = LEVEL_W'(16);
  localparam logic [LEVEL_W-1:0] LEVEL_SECOND_RST = LEVEL_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SECOND = CFG_IDX_W'(1);

  localparam logic MODE_ANGLE  = 1'b0;
  localparam logic MODE_BUTTON = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_LOAD,
    ST_DIV,
    ST_FIX
  } ats_state_t;

  typedef struct packed {
    logic take;
    logic add;
    logic load;
    logic step;
    logic emit;
  } ats_cmd_t;

  typedef struct packed {
    logic primed;
    logic d_zero;
    logic div_last;
    logic q_zero;
    logic out_free;
  } ats_status_t;

endpackage

// ===== sv/ats_ctrl.sv =====
// Controller state machine: request intake, residue update, divide sequencing, result hand-off.
module ats_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_mode,
  output logic                in_ready,
  input  ats_pkg::ats_status_t status,
  output ats_pkg::ats_cmd_t    cmd
);

  ats_pkg::ats_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ats_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ats_pkg::ST_IDLE: begin
        if (in_valid && in_mode == ats_pkg::MODE_ANGLE && status.primed) begin
          state_nxt = ats_pkg::ST_SUM;
        end
      end
      ats_pkg::ST_SUM: begin
        state_nxt = status.d_zero ? ats_pkg::ST_IDLE : ats_pkg::ST_LOAD;
      end
      ats_pkg::ST_LOAD: begin
        state_nxt = ats_pkg::ST_DIV;
      end
      ats_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_nxt = ats_pkg::ST_FIX;
        end
      end
      ats_pkg::ST_FIX: begin
        // hold here while a nonzero result waits for the previous one to be taken
        if (status.q_zero || status.out_free) begin
          state_nxt = ats_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ats_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ats_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ats_pkg::ST_SUM: begin
        cmd.add = !status.d_zero;
      end
      ats_pkg::ST_LOAD: begin
        cmd.load = 1'b1;
      end
      ats_pkg::ST_DIV: begin
        cmd.step = 1'b1;
      end
      ats_pkg::ST_FIX: begin
        cmd.emit = !status.q_zero && status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/ats_datapath.sv =====
// Datapath: angle state, wrapped difference, residue, restoring divider and output register.
module ats_datapath #(
  parameter int ANGLE_BITS = ats_pkg::ANGLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_mode,
  input  logic [ats_pkg::ANGLE_IN_W-1:0]        in_angle,
  input  logic                                  in_button_level,
  input  logic                                  cfg_we,
  input  logic [ats_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ats_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [ats_pkg::AMOUNT_W-1:0]   out_scroll_amount,
  input  ats_pkg::ats_cmd_t                     cmd,
  output ats_pkg::ats_status_t                  status
);

  localparam int RES_W     = ANGLE_BITS + 2;
  localparam int MAG_W     = ANGLE_BITS + 1;
  localparam int CNT_W     = $clog2(MAG_W);
  localparam int LW        = ats_pkg::LEVEL_W;
  localparam int AW        = ats_pkg::AMOUNT_W;
  localparam int HALF_TURN = 1 << (ANGLE_BITS - 1);
  localparam int FULL_TURN = 1 << ANGLE_BITS;
  localparam logic signed [RES_W-1:0] HALF_S = RES_W'(HALF_TURN);
  localparam logic signed [RES_W-1:0] FULL_S = RES_W'(FULL_TURN);

  logic [LW-1:0]              level_first_r, level_first_nxt;
  logic [LW-1:0]              level_second_r, level_second_nxt;
  logic [ANGLE_BITS-1:0]      prev_angle_r, prev_angle_nxt;
  logic                       primed_r, primed_nxt;
  logic                       last_button_r, last_button_nxt;
  logic                       level_select_r, level_select_nxt;
  logic signed [RES_W-1:0]    residue_r, residue_nxt;
  logic signed [RES_W-1:0]    d_r, d_nxt;
  logic                       sign_r, sign_nxt;
  logic [MAG_W-1:0]           quo_r, quo_nxt;
  logic [LW-1:0]              rem_r, rem_nxt;
  logic [LW-1:0]              ticks_r, ticks_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [AW-1:0]              out_amount_r, out_amount_nxt;

  logic [ANGLE_BITS+ats_pkg::ANGLE_IN_W-1:0] angle_ext;
  logic [ANGLE_BITS-1:0]      angle_use;
  logic signed [RES_W-1:0]    diff_raw;
  logic signed [RES_W-1:0]    diff_wrap;
  logic signed [RES_W-1:0]    res_abs;
  logic [LW-1:0]              ticks_sel;
  logic [LW:0]                trial;
  logic [LW:0]                trial_sub;
  logic signed [MAG_W:0]      q_signed;
  logic [MAG_W+AW:0]          q_ext;
  logic signed [RES_W-1:0]    rem_ext;

  always_comb begin
    angle_ext = {{ANGLE_BITS{1'b0}}, in_angle};
    angle_use = angle_ext[ANGLE_BITS-1:0];
    diff_raw  = $signed({2'b00, angle_use}) - $signed({2'b00, prev_angle_r});
    if (diff_raw > HALF_S) begin
      diff_wrap = diff_raw - FULL_S;
    end else if (diff_raw < -HALF_S) begin
      diff_wrap = diff_raw + FULL_S;
    end else begin
      diff_wrap = diff_raw;
    end
    res_abs   = residue_r[RES_W-1] ? -residue_r : residue_r;
    ticks_sel = level_select_r ? level_second_r : level_first_r;
    if (ticks_sel == '0) begin
      ticks_sel = LW'(1);
    end
    trial     = {rem_r, quo_r[MAG_W-1]};
    trial_sub = trial - {1'b0, ticks_r};
    q_signed  = sign_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    q_ext     = {{AW{q_signed[MAG_W]}}, q_signed};
    rem_ext   = $signed({{(RES_W-LW){1'b0}}, rem_r});
  end

  always_comb begin
    level_first_nxt  = level_first_r;
    level_second_nxt = level_second_r;
    prev_angle_nxt   = prev_angle_r;
    primed_nxt       = primed_r;
    last_button_nxt  = last_button_r;
    level_select_nxt = level_select_r;
    residue_nxt      = residue_r;
    d_nxt            = d_r;
    sign_nxt         = sign_r;
    quo_nxt          = quo_r;
    rem_nxt          = rem_r;
    ticks_nxt        = ticks_r;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_amount_nxt   = out_amount_r;

    if (cfg_we) begin
      case (cfg_index)
        ats_pkg::REG_LEVEL_FIRST:  level_first_nxt  = cfg_wdata[LW-1:0];
        ats_pkg::REG_LEVEL_SECOND: level_second_nxt = cfg_wdata[LW-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end

    if (cmd.take) begin
      if (in_mode == ats_pkg::MODE_BUTTON) begin
        if (in_button_level && !last_button_r) begin
          level_select_nxt = !level_select_r;
        end
        last_button_nxt = in_button_level;
      end else begin
        prev_angle_nxt = angle_use;
        primed_nxt     = 1'b1;
        d_nxt          = diff_wrap;
      end
    end

    if (cmd.add) begin
      residue_nxt = residue_r + d_r;
    end

    if (cmd.load) begin
      sign_nxt  = residue_r[RES_W-1];
      quo_nxt   = res_abs[MAG_W-1:0];
      rem_nxt   = '0;
      ticks_nxt = ticks_sel;
      cnt_nxt   = CNT_W'(MAG_W - 1);
    end

    if (cmd.step) begin
      if (!trial_sub[LW]) begin
        rem_nxt = trial_sub[LW-1:0];
        quo_nxt = {quo_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[LW-1:0];
        quo_nxt = {quo_r[MAG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end

    if (cmd.emit) begin
      // remainder keeps the sign of the residue under truncating division
      residue_nxt    = sign_r ? -rem_ext : rem_ext;
      out_valid_nxt  = 1'b1;
      out_amount_nxt = q_ext[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_first_r  <= ats_pkg::LEVEL_FIRST_RST;
      level_second_r <= ats_pkg::LEVEL_SECOND_RST;
      prev_angle_r   <= '0;
      primed_r       <= 1'b0;
      last_button_r  <= 1'b0;
      level_select_r <= 1'b0;
      residue_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      level_first_r  <= level_first_nxt;
      level_second_r <= level_second_nxt;
      prev_angle_r   <= prev_angle_nxt;
      primed_r       <= primed_nxt;
      last_button_r  <= last_button_nxt;
      level_select_r <= level_select_nxt;
      residue_r      <= residue_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r          <= d_nxt;
    sign_r       <= sign_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    ticks_r      <= ticks_nxt;
    cnt_r        <= cnt_nxt;
    out_amount_r <= out_amount_nxt;
  end

  always_comb begin
    status.primed   = primed_r;
    status.d_zero   = (d_r == '0);
    status.div_last = (cnt_r == '0);
    status.q_zero   = (quo_r == '0);
    status.out_free = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_scroll_amount = $signed(out_amount_r);

endmodule

// ===== sv/angle_to_scroll_accumulator.sv =====
// Top level of the angle to scroll accumulator: controller and datapath.
//
// Input channel (in_valid/in_ready): one request is an angle sample
// (in_mode 0, in_angle) or a sensitivity button poll (in_mode 1,
// in_button_level). Output channel (out_valid/out_ready): one signed,
// nonzero scroll amount per angle sample whose quotient is nonzero.
// Configuration: cfg_we with cfg_index 0 writes level_first, index 1
// level_second; other indexes are dropped. Write only while idle.
// Sequence: button polls and the first (priming) angle sample finish at
// intake. Every later angle sample runs through intake, residue add,
// divider load, ANGLE_BITS + 1 steps of the one-bit-per-cycle restoring
// divider, and result hand-off. A zero difference finishes at the residue
// add step and skips the divider and the hand-off.
// The result sits in an output register, so the next request is taken
// while it waits. A stalled receiver holds a later result in the hand-off
// step and blocks further intake until the register frees up.
// Reset (synchronous, rst_n low) clears the angle state, residue, button
// history and level choice, and restores both levels (16 and 8).
module angle_to_scroll_accumulator #(
  parameter int ANGLE_BITS = ats_pkg::ANGLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic [ats_pkg::ANGLE_IN_W-1:0]      in_angle,
  input  logic                                in_button_level,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ats_pkg::AMOUNT_W-1:0] out_scroll_amount,
  input  logic                                cfg_we,
  input  logic [ats_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ats_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  ats_pkg::ats_cmd_t    cmd;
  ats_pkg::ats_status_t status;

  ats_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ats_datapath #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mode           (in_mode),
    .in_angle          (in_angle),
    .in_button_level   (in_button_level),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_scroll_amount (out_scroll_amount),
    .cmd               (cmd),
    .status            (status)
  );

endmodule

// ===== sv/ats_checker.sv =====
// Port-level checks for the angle to scroll accumulator, bound to the top level.
module ats_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [ats_pkg::AMOUNT_W-1:0] out_scroll_amount
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scroll_amount))
    else $error("result changed or dropped while stalled");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_scroll_amount != '0)
    else $error("zero scroll amount presented");

  // no result can appear in the cycle right after a request is taken
  a_no_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after intake");

  a_reset_clear: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind angle_to_scroll_accumulator ats_checker u_ats_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_scroll_amount (out_scroll_amount)
);

// ===== dv/angle_to_scroll_accumulator_tb.sv =====
// Self-checking testbench for the angle to scroll accumulator, with a scroll predictor.
module angle_to_scroll_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULL_TURN    = 1 << ats_pkg::ANGLE_BITS_DEF;
  localparam int HALF_TURN    = 1 << (ats_pkg::ANGLE_BITS_DEF - 1);
  localparam int SETTLE_CYCLES = 2 * (ats_pkg::ANGLE_BITS_DEF + 5);
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int IDLE_PCT     = 19;
  localparam int MAX_GAP      = 20;

  // Indexes past the register list; writes there must be dropped
  localparam logic [ats_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = ats_pkg::CFG_IDX_W'(2);
  localparam logic [ats_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = ats_pkg::CFG_IDX_W'(3);

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                in_mode = ats_pkg::MODE_ANGLE;
  logic [ats_pkg::ANGLE_IN_W-1:0]      in_angle = '0;
  logic                                in_button_level = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [ats_pkg::AMOUNT_W-1:0] out_scroll_amount;
  logic                                cfg_we = 1'b0;
  logic [ats_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [ats_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;

  // Predictor state
  logic [ats_pkg::ANGLE_IN_W-1:0] track_prev_angle;
  logic                           track_primed;
  int                             track_residue;
  logic                           track_last_button;
  logic                           track_level_sel;
  logic [ats_pkg::LEVEL_W-1:0]    track_level_first;
  logic [ats_pkg::LEVEL_W-1:0]    track_level_second;

  logic signed [ats_pkg::AMOUNT_W-1:0] pending_scroll[$];
  logic signed [ats_pkg::AMOUNT_W-1:0] wanted_scroll;
  int                                  fail_count = 0;
  int                                  quiet_cycles = 0;
  int                                  hold_left = 0;
  bit                                  hold_req = 1'b0;
  bit                                  calm = 1'b0;
  logic [ats_pkg::ANGLE_IN_W-1:0]      last_angle_sent = '0;

  angle_to_scroll_accumulator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_angle          (in_angle),
    .in_button_level   (in_button_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scroll_amount (out_scroll_amount),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic predict_scroll(input logic mode, input logic [ats_pkg::ANGLE_IN_W-1:0] angle,
                                input logic button);
    int delta;
    int ticks;
    int quot;
    if (mode == ats_pkg::MODE_BUTTON) begin
      if (button && !track_last_button) track_level_sel = !track_level_sel;
      track_last_button = button;
    end else if (!track_primed) begin
      track_prev_angle = angle;
      track_primed = 1'b1;
    end else begin
      delta = int'(angle) - int'(track_prev_angle);
      if (delta > HALF_TURN) delta -= FULL_TURN;
      if (delta < -HALF_TURN) delta += FULL_TURN;
      track_prev_angle = angle;
      if (delta != 0) begin
        track_residue += delta;
        ticks = track_level_sel ? int'(track_level_second) : int'(track_level_first);
        if (ticks == 0) ticks = 1;
        quot = track_residue / ticks;
        if (quot != 0) begin
          track_residue -= quot * ticks;
          pending_scroll.push_back(ats_pkg::AMOUNT_W'(quot));
        end
      end
    end
  endtask

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_scroll(in_mode, in_angle, in_button_level);
      if (out_valid && out_ready) begin
        if (pending_scroll.size() == 0) begin
          $display("%0t: unexpected scroll amount, expected none, got %0d",
                   $time, out_scroll_amount);
          fail_count++;
        end else begin
          wanted_scroll = pending_scroll.pop_front();
          if (out_scroll_amount !== wanted_scroll) begin
            $display("%0t: scroll amount mismatch, expected %0d, got %0d",
                     $time, wanted_scroll, out_scroll_amount);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver: random back-off, or a long hold when asked
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("** angle_to_scroll_accumulator: FAILED **");
      $finish;
    end
  end

  task automatic send_req(input logic mode, input logic [ats_pkg::ANGLE_IN_W-1:0] angle,
                          input logic button);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_angle        <= angle;
    in_button_level <= button;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_angle(input logic [ats_pkg::ANGLE_IN_W-1:0] angle);
    last_angle_sent = angle;
    send_req(ats_pkg::MODE_ANGLE, angle, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_button(input logic level);
    send_req(ats_pkg::MODE_BUTTON, ats_pkg::ANGLE_IN_W'($urandom), level);
  endtask

  // Drop valid, drain all results, then let any silent request finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_scroll.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ats_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ats_pkg::LEVEL_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      ats_pkg::REG_LEVEL_FIRST:  track_level_first = value;
      ats_pkg::REG_LEVEL_SECOND: track_level_second = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [ats_pkg::ANGLE_IN_W-1:0] pick_angle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return last_angle_sent + ats_pkg::ANGLE_IN_W'($urandom_range(0, 80))
                          - ats_pkg::ANGLE_IN_W'(40);
    if (roll < 65) return last_angle_sent + ats_pkg::ANGLE_IN_W'($urandom_range(0, 600))
                          - ats_pkg::ANGLE_IN_W'(300);
    if (roll < 75) return last_angle_sent;
    if (roll < 80) return last_angle_sent + ats_pkg::ANGLE_IN_W'(HALF_TURN);
    return ats_pkg::ANGLE_IN_W'($urandom);
  endfunction

  task automatic run_mix(input int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 8) begin
        send_button(1'($urandom_range(0, 1)));
      end else begin
        send_angle(pick_angle());
      end
    end
  endtask

  task automatic test_priming_and_wrap();
    send_angle(ats_pkg::ANGLE_IN_W'(FULL_TURN - 1));  // priming, no result
    send_angle('0);                                   // wraps to +1
    send_angle(ats_pkg::ANGLE_IN_W'(HALF_TURN));      // exactly half a turn forward
    send_angle(ats_pkg::ANGLE_IN_W'(HALF_TURN));      // zero difference
    send_angle('0);                                   // exactly half a turn back
    settle();
  endtask

  task automatic test_sensitivity_button();
    send_button(1'b1);
    send_angle(ats_pkg::ANGLE_IN_W'(100));
    send_button(1'b1);                       // held, no toggle
    send_angle(ats_pkg::ANGLE_IN_W'(90));
    send_button(1'b0);
    send_button(1'b0);
    send_button(1'b1);                       // back to the first level
    send_angle(ats_pkg::ANGLE_IN_W'(200));
    settle();
  endtask

  task automatic test_level_registers();
    write_reg(ats_pkg::REG_LEVEL_FIRST, 8'd1);
    write_reg(ats_pkg::REG_LEVEL_SECOND, 8'd255);
    send_angle(ats_pkg::ANGLE_IN_W'(4000));
    send_button(1'b0);
    send_button(1'b1);
    send_angle(ats_pkg::ANGLE_IN_W'(3000));
    settle();
    // zero level behaves as one
    write_reg(ats_pkg::REG_LEVEL_SECOND, 8'd0);
    write_reg(REG_SPARE_LO, 8'hFF);
    write_reg(REG_SPARE_HI, 8'h00);
    send_angle(ats_pkg::ANGLE_IN_W'(3001));
    send_angle(ats_pkg::ANGLE_IN_W'(1000));
    settle();
    write_reg(ats_pkg::REG_LEVEL_FIRST, 8'd0);
    write_reg(ats_pkg::REG_LEVEL_SECOND, 8'd255);
    send_button(1'b0);
    send_angle(ats_pkg::ANGLE_IN_W'(1500));
    settle();
  endtask

  task automatic test_random_levels();
    write_reg(ats_pkg::REG_LEVEL_FIRST, 8'd255);
    write_reg(ats_pkg::REG_LEVEL_SECOND, 8'd1);
    run_mix(200);
    settle();
    write_reg(ats_pkg::REG_LEVEL_FIRST, 8'd1);
    write_reg(ats_pkg::REG_LEVEL_SECOND, 8'd255);
    run_mix(200);
    settle();
    write_reg(ats_pkg::REG_LEVEL_FIRST, ats_pkg::LEVEL_W'($urandom));
    write_reg(ats_pkg::REG_LEVEL_SECOND, ats_pkg::LEVEL_W'($urandom));
    run_mix(200);
    settle();
    write_reg(ats_pkg::REG_LEVEL_FIRST, ats_pkg::LEVEL_W'($urandom_range(2, 40)));
    write_reg(ats_pkg::REG_LEVEL_SECOND, ats_pkg::LEVEL_W'($urandom_range(2, 40)));
    run_mix(200);
    settle();
    write_reg(ats_pkg::REG_LEVEL_FIRST, ats_pkg::LEVEL_FIRST_RST);
    write_reg(ats_pkg::REG_LEVEL_SECOND, ats_pkg::LEVEL_SECOND_RST);
    run_mix(200);
    settle();
  endtask

  task automatic test_calm_stretch();
    write_reg(ats_pkg::REG_LEVEL_FIRST, 8'd3);
    write_reg(ats_pkg::REG_LEVEL_SECOND, 8'd5);
    calm = 1'b1;
    run_mix(200);
    settle();
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    write_reg(ats_pkg::REG_LEVEL_FIRST, 8'd2);
    write_reg(ats_pkg::REG_LEVEL_SECOND, 8'd3);
    hold_req = 1'b1;
    // large steps so nearly every request yields a result and the block backs up
    repeat (60) send_angle(last_angle_sent + ats_pkg::ANGLE_IN_W'($urandom_range(100, 1500)));
    settle();
  endtask

  initial begin
    track_prev_angle   = '0;
    track_primed       = 1'b0;
    track_residue      = 0;
    track_last_button  = 1'b0;
    track_level_sel    = 1'b0;
    track_level_first  = ats_pkg::LEVEL_FIRST_RST;
    track_level_second = ats_pkg::LEVEL_SECOND_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_priming_and_wrap();
    test_sensitivity_button();
    test_level_registers();
    test_random_levels();
    test_calm_stretch();
    test_backpressure();

    if (pending_scroll.size() != 0) begin
      $display("%0t: %0d scroll amounts never arrived", $time, pending_scroll.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** angle_to_scroll_accumulator: PASSED **");
    end else begin
      $display("** angle_to_scroll_accumulator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ats_pkg.sv
sv/ats_ctrl.sv
sv/ats_datapath.sv
sv/angle_to_scroll_accumulator.sv
sv/ats_checker.sv
dv/angle_to_scroll_accumulator_tb.sv
